// ===== hw/rtl/ral_pkg.sv =====
package ral_pkg;

    localparam int OFF_BITS    = 32;
    localparam int TAG_BITS    = 16;
    localparam int ADDR_BITS   = 64;
    localparam int ADDEND_BITS = OFF_BITS + 1;
    localparam int STATUS_BITS = 4;
    localparam int CFG_IDX_BITS = 2;

    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK         = 4'd0,
        ST_ZERO       = 4'd1,
        ST_NEG        = 4'd2,
        ST_RANGE      = 4'd3,
        ST_GRAN       = 4'd4,
        ST_OVERLAP    = 4'd5,
        ST_ADDR       = 4'd6,
        ST_IMPOSSIBLE = 4'd7,
        ST_ABORT      = 4'd8
    } t_status;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SECTION_SIZE    = 2'd0,
        CFG_SECTION_ADDRESS = 2'd1,
        CFG_COMPRESSED_MODE = 2'd2
    } t_cfg_idx;

    // classified region, front to back
    typedef struct packed {
        t_status               code;
        logic [OFF_BITS-1:0]   offset;
        logic [OFF_BITS-1:0]   addend;
        logic [OFF_BITS-1:0]   mask;
        logic [OFF_BITS-1:0]   neg_base;
        logic [TAG_BITS-1:0]   tag;
        logic                  last;
    } t_cls;

endpackage

// ===== hw/rtl/ral_front.sv =====
module ral_front
    import ral_pkg::*;
(
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [OFF_BITS-1:0]           i_region_offset,
    input  logic signed [ADDEND_BITS-1:0] i_padding_addend,
    input  logic [TAG_BITS-1:0]           i_source_tag,
    input  logic                          i_last_region,
    input  logic [OFF_BITS-1:0]           i_section_size,
    input  logic [OFF_BITS-1:0]           i_section_address_lo,
    input  logic                          i_compressed_mode,
    input  logic                          i_queue_full,
    output logic                          o_push,
    output t_cls                          o_cls
);

    logic [OFF_BITS-1:0] addend_lo;
    logic [OFF_BITS-1:0] mask;
    logic [OFF_BITS-1:0] room;
    logic                gran_bad;

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    assign addend_lo = i_padding_addend[OFF_BITS-1:0];
    assign room      = i_section_size - i_region_offset;
    assign gran_bad  = i_compressed_mode ? addend_lo[0] : (|addend_lo[1:0]);

    // all ones up to the top set bit: alignment minus one
    always_comb begin
        mask = addend_lo;
        for (int k = 1; k < OFF_BITS; k = k * 2) begin
            mask = mask | (mask >> k);
        end
    end

    always_comb begin
        o_cls.offset   = i_region_offset;
        o_cls.addend   = addend_lo;
        o_cls.mask     = mask;
        o_cls.neg_base = OFF_BITS'(0) - i_section_address_lo - i_region_offset;
        o_cls.tag      = i_source_tag;
        o_cls.last     = i_last_region;
        if (i_padding_addend[ADDEND_BITS-1]) begin
            o_cls.code = ST_NEG;
        end else if (i_region_offset > i_section_size || addend_lo > room) begin
            o_cls.code = ST_RANGE;
        end else if (addend_lo == '0) begin
            o_cls.code = ST_ZERO;
        end else if (gran_bad) begin
            o_cls.code = ST_GRAN;
        end else begin
            o_cls.code = ST_OK;
        end
    end

endmodule

// ===== hw/rtl/ral_queue.sv =====
module ral_queue
    import ral_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cls o_data
);

    t_cls                  r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_count;
    logic [Q_PTR_BITS-1:0] n_wr_ptr;
    logic [Q_PTR_BITS-1:0] n_rd_ptr;
    logic [Q_CNT_BITS-1:0] n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == Q_CNT_BITS'(Q_DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_BITS'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count not reduced on pop");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

// ===== hw/rtl/ral_back.sv =====
module ral_back
    import ral_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_cls                 i_cls,
    output logic                 o_pop,
    input  logic [OFF_BITS-1:0]  i_section_size,
    input  logic [ADDR_BITS-1:0] i_section_address,
    input  logic                 i_compressed_mode,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STATUS_BITS-1:0] o_status,
    output logic [OFF_BITS-1:0]  o_output_offset,
    output logic [OFF_BITS-1:0]  o_kept_size,
    output logic [TAG_BITS-1:0]  o_echo_tag,
    output logic [OFF_BITS-1:0]  o_final_size,
    output logic                 o_is_last
);

    logic [OFF_BITS-1:0] r_deleted;
    logic [OFF_BITS-1:0] r_prev_end;
    logic                r_seen;
    logic                r_err;
    logic                r_out_valid;
    t_status             r_status;
    logic [OFF_BITS-1:0] r_output_offset;
    logic [OFF_BITS-1:0] r_kept_size;
    logic [TAG_BITS-1:0] r_echo_tag;
    logic [OFF_BITS-1:0] r_final_size;
    logic                r_is_last;

    logic [OFF_BITS-1:0] n_deleted;
    logic [OFF_BITS-1:0] pos;
    logic [OFF_BITS-1:0] keep;
    logic                addr_ovf;
    logic                keep_bad;
    logic                is_err;
    logic                fire;
    t_status             status;

    assign fire  = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_pop = fire;

    assign pos  = i_cls.offset - r_deleted;
    // low bits of minus the region's load address
    assign keep = (i_cls.neg_base + r_deleted) & i_cls.mask;
    assign addr_ovf = (&i_section_address[ADDR_BITS-1:OFF_BITS])
        && (pos > ~i_section_address[OFF_BITS-1:0]);
    assign keep_bad = (keep > i_cls.addend)
        || (i_compressed_mode ? keep[0] : (|keep[1:0]));

    always_comb begin
        if (r_err) begin
            status = ST_ABORT;
        end else if (i_cls.code != ST_OK) begin
            status = i_cls.code;
        end else if (r_seen && i_cls.offset < r_prev_end) begin
            status = ST_OVERLAP;
        end else if (addr_ovf) begin
            status = ST_ADDR;
        end else if (keep_bad) begin
            status = ST_IMPOSSIBLE;
        end else begin
            status = ST_OK;
        end
    end

    assign is_err    = (status != ST_OK) && (status != ST_ZERO) && (status != ST_ABORT);
    assign n_deleted = (status == ST_OK) ? r_deleted + i_cls.addend - keep : r_deleted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deleted   <= '0;
            r_prev_end  <= '0;
            r_seen      <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (fire) begin
                if (i_cls.last) begin
                    r_deleted  <= '0;
                    r_prev_end <= '0;
                    r_seen     <= 1'b0;
                    r_err      <= 1'b0;
                end else begin
                    r_deleted <= n_deleted;
                    if (status == ST_OK) begin
                        r_prev_end <= i_cls.offset + i_cls.addend;
                        r_seen     <= 1'b1;
                    end
                    if (is_err) begin
                        r_err <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status        <= status;
            r_output_offset <= (status == ST_OK || status == ST_ZERO) ? pos : '0;
            r_kept_size     <= (status == ST_OK) ? keep : '0;
            r_echo_tag      <= i_cls.tag;
            r_final_size    <= (i_cls.last && (status == ST_OK || status == ST_ZERO))
                ? i_section_size - n_deleted : '0;
            r_is_last       <= i_cls.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_output_offset = r_output_offset;
    assign o_kept_size     = r_kept_size;
    assign o_echo_tag      = r_echo_tag;
    assign o_final_size    = r_final_size;
    assign o_is_last       = r_is_last;

    a_err_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK && r_status != ST_ZERO)
        |-> (r_output_offset == '0 && r_kept_size == '0 && r_final_size == '0))
        else $error("error result carries layout data");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_cls.last) |=> (r_deleted == '0 && !r_seen && !r_err))
        else $error("section state not cleared after last item");

    a_err_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && is_err && !i_cls.last) |=> r_err)
        else $error("error not latched");

endmodule

// ===== hw/rtl/riscv_align_region_layout.sv =====
// Lays out the alignment padding regions of one section, taking them in
// ascending offset order, one item per clock cycle sustained while the
// output is not stalled. An accepted item is registered in the queue and
// its result in the output register: the front classifies the item and
// pushes it into a two-entry queue, and the back applies the running
// deleted-byte count and drives the output register. The rate is set by
// the back's deleted-count update that each region depends on.
// The first error aborts the rest of the section; the result of a last
// region that is OK or zero-padded carries the relaxed size, and every
// last region clears the per-section state.
// Configuration must be written only while no item is in flight.
module riscv_align_region_layout
    import ral_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [ADDR_BITS-1:0]          i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [OFF_BITS-1:0]           i_region_offset,
    input  logic signed [ADDEND_BITS-1:0] i_padding_addend,
    input  logic [TAG_BITS-1:0]           i_source_tag,
    input  logic                          i_last_region,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [STATUS_BITS-1:0]        o_status,
    output logic [OFF_BITS-1:0]           o_output_offset,
    output logic [OFF_BITS-1:0]           o_kept_size,
    output logic [TAG_BITS-1:0]           o_echo_tag,
    output logic [OFF_BITS-1:0]           o_final_size,
    output logic                          o_is_last
);

    logic [OFF_BITS-1:0]  r_section_size;
    logic [ADDR_BITS-1:0] r_section_address;
    logic                 r_compressed_mode;

    logic push;
    logic pop;
    logic q_valid;
    logic q_full;
    t_cls front_cls;
    t_cls head_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section_size    <= '0;
            r_section_address <= '0;
            r_compressed_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SECTION_SIZE: begin
                    r_section_size <= i_cfg_wr_data[OFF_BITS-1:0];
                end
                CFG_SECTION_ADDRESS: begin
                    r_section_address <= i_cfg_wr_data;
                end
                CFG_COMPRESSED_MODE: begin
                    r_compressed_mode <= i_cfg_wr_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    ral_front u_front (
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_region_offset      (i_region_offset),
        .i_padding_addend     (i_padding_addend),
        .i_source_tag         (i_source_tag),
        .i_last_region        (i_last_region),
        .i_section_size       (r_section_size),
        .i_section_address_lo (r_section_address[OFF_BITS-1:0]),
        .i_compressed_mode    (r_compressed_mode),
        .i_queue_full         (q_full),
        .o_push               (push),
        .o_cls                (front_cls)
    );

    ral_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (head_cls)
    );

    ral_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_cls             (head_cls),
        .o_pop             (pop),
        .i_section_size    (r_section_size),
        .i_section_address (r_section_address),
        .i_compressed_mode (r_compressed_mode),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_output_offset   (o_output_offset),
        .o_kept_size       (o_kept_size),
        .o_echo_tag        (o_echo_tag),
        .o_final_size      (o_final_size),
        .o_is_last         (o_is_last)
    );

endmodule

// ===== tb/sv/riscv_align_region_layout_checker.sv =====
`timescale 1ns / 1ps

module riscv_align_region_layout_checker
    import ral_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [ADDR_BITS-1:0]   i_cfg_wr_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [OFF_BITS-1:0]    i_region_offset,
    input  logic [ADDEND_BITS-1:0] i_padding_addend,
    input  logic [TAG_BITS-1:0]    i_source_tag,
    input  logic                   i_last_region,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [STATUS_BITS-1:0] i_status,
    input  logic [OFF_BITS-1:0]    i_output_offset,
    input  logic [OFF_BITS-1:0]    i_kept_size,
    input  logic [TAG_BITS-1:0]    i_echo_tag,
    input  logic [OFF_BITS-1:0]    i_final_size,
    input  logic                   i_is_last,
    output int                     o_fail_count,
    output int                     o_outstanding
);

    typedef struct packed {
        t_status             status;
        logic [OFF_BITS-1:0] out_offset;
        logic [OFF_BITS-1:0] keep_bytes;
        logic [TAG_BITS-1:0] echo_tag;
        logic [OFF_BITS-1:0] final_size;
        logic                is_last;
    } t_layout_result;

    logic [OFF_BITS-1:0]  cfg_size;
    logic [ADDR_BITS-1:0] cfg_addr;
    logic                 cfg_compressed;

    logic [OFF_BITS-1:0]  deleted_bytes;
    logic [OFF_BITS-1:0]  prev_region_end;
    logic                 seen_region;
    logic                 error_latched;

    t_layout_result pending_layouts[$];
    t_layout_result oldest_layout;
    int             fail_total;

    function automatic t_layout_result predict_layout(
        input logic [OFF_BITS-1:0]    offset,
        input logic [ADDEND_BITS-1:0] addend,
        input logic [TAG_BITS-1:0]    tag,
        input logic                   last
    );
        t_layout_result      res;
        logic [OFF_BITS-1:0] gran_mask;
        logic [OFF_BITS-1:0] pos;
        logic [64:0]         place_wide;
        logic [63:0]         align;
        logic [63:0]         mask;
        logic [63:0]         keep_wide;
        res = '0;
        res.status = ST_OK;
        res.echo_tag = tag;
        res.is_last = last;
        gran_mask = cfg_compressed ? 32'd1 : 32'd3;
        pos = offset - deleted_bytes;
        if (error_latched) begin
            res.status = ST_ABORT;
        end else if (addend[ADDEND_BITS-1]) begin
            res.status = ST_NEG;
        end else if (offset > cfg_size || addend[OFF_BITS-1:0] > cfg_size - offset) begin
            res.status = ST_RANGE;
        end else if (addend[OFF_BITS-1:0] == '0) begin
            res.status = ST_ZERO;
            res.out_offset = pos;
        end else if ((addend[OFF_BITS-1:0] & gran_mask) != '0) begin
            res.status = ST_GRAN;
        end else if (seen_region && offset < prev_region_end) begin
            res.status = ST_OVERLAP;
        end else begin
            place_wide = {1'b0, cfg_addr} + {33'd0, pos};
            if (place_wide[64]) begin
                res.status = ST_ADDR;
            end else begin
                // smallest power of two above the padding
                align = 64'd1;
                while (align <= {31'd0, addend})
                    align = align << 1;
                mask = align - 64'd1;
                keep_wide = (align - (place_wide[63:0] & mask)) & mask;
                if (keep_wide > {32'd0, addend[OFF_BITS-1:0]}
                        || (keep_wide[OFF_BITS-1:0] & gran_mask) != '0) begin
                    res.status = ST_IMPOSSIBLE;
                end else begin
                    res.out_offset = pos;
                    res.keep_bytes = keep_wide[OFF_BITS-1:0];
                    deleted_bytes = deleted_bytes
                        + (addend[OFF_BITS-1:0] - keep_wide[OFF_BITS-1:0]);
                    prev_region_end = offset + addend[OFF_BITS-1:0];
                    seen_region = 1'b1;
                end
            end
        end
        if (res.status >= ST_NEG && res.status != ST_ABORT)
            error_latched = 1'b1;
        if (last && res.status <= ST_ZERO)
            res.final_size = cfg_size - deleted_bytes;
        if (last) begin
            deleted_bytes = '0;
            prev_region_end = '0;
            seen_region = 1'b0;
            error_latched = 1'b0;
        end
        return res;
    endfunction

    task automatic check_field(input string field_name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", field_name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_size = '0;
            cfg_addr = '0;
            cfg_compressed = 1'b0;
            deleted_bytes = '0;
            prev_region_end = '0;
            seen_region = 1'b0;
            error_latched = 1'b0;
            pending_layouts.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_layouts.size() == 0) begin
                    $error("result with no item pending, echo_tag %0h", i_echo_tag);
                    fail_total++;
                end else begin
                    oldest_layout = pending_layouts.pop_front();
                    check_field("o_status", 64'(oldest_layout.status), 64'(i_status));
                    check_field("o_output_offset", 64'(oldest_layout.out_offset),
                                64'(i_output_offset));
                    check_field("o_kept_size", 64'(oldest_layout.keep_bytes),
                                64'(i_kept_size));
                    check_field("o_echo_tag", 64'(oldest_layout.echo_tag), 64'(i_echo_tag));
                    check_field("o_final_size", 64'(oldest_layout.final_size),
                                64'(i_final_size));
                    check_field("o_is_last", 64'(oldest_layout.is_last), 64'(i_is_last));
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SECTION_SIZE:    cfg_size = i_cfg_wr_data[OFF_BITS-1:0];
                    CFG_SECTION_ADDRESS: cfg_addr = i_cfg_wr_data;
                    CFG_COMPRESSED_MODE: cfg_compressed = i_cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                pending_layouts.push_back(predict_layout(i_region_offset, i_padding_addend,
                                                         i_source_tag, i_last_region));
        end
        o_outstanding = pending_layouts.size();
        o_fail_count = fail_total;
    end

endmodule

// ===== tb/sv/riscv_align_region_layout_tb.sv =====
`timescale 1ns / 1ps

module riscv_align_region_layout_tb
    import ral_pkg::*;
();

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INDEX_UNUSED = 2'd3;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [ADDR_BITS-1:0]   i_cfg_wr_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [OFF_BITS-1:0]    i_region_offset;
    logic [ADDEND_BITS-1:0] i_padding_addend;
    logic [TAG_BITS-1:0]    i_source_tag;
    logic                   i_last_region;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [STATUS_BITS-1:0] o_status;
    logic [OFF_BITS-1:0]    o_output_offset;
    logic [OFF_BITS-1:0]    o_kept_size;
    logic [TAG_BITS-1:0]    o_echo_tag;
    logic [OFF_BITS-1:0]    o_final_size;
    logic                   o_is_last;

    int fail_count;
    int outstanding;
    int sent_items;
    int burst_left;

    logic [OFF_BITS-1:0] cur_size;
    logic [OFF_BITS-1:0] cur_gran_mask;

    riscv_align_region_layout dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_region_offset  (i_region_offset),
        .i_padding_addend (i_padding_addend),
        .i_source_tag     (i_source_tag),
        .i_last_region    (i_last_region),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_output_offset  (o_output_offset),
        .o_kept_size      (o_kept_size),
        .o_echo_tag       (o_echo_tag),
        .o_final_size     (o_final_size),
        .o_is_last        (o_is_last)
    );

    riscv_align_region_layout_checker layout_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_region_offset  (i_region_offset),
        .i_padding_addend (i_padding_addend),
        .i_source_tag     (i_source_tag),
        .i_last_region    (i_last_region),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_status         (o_status),
        .i_output_offset  (o_output_offset),
        .i_kept_size      (o_kept_size),
        .i_echo_tag       (o_echo_tag),
        .i_final_size     (o_final_size),
        .i_is_last        (o_is_last),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // receiver stall pattern
    initial begin : out_stall_gen
        int          left;
        t_stall_mode mode;
        i_out_stall = 1'b0;
        left = 0;
        mode = STALL_NONE;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = t_stall_mode'($urandom_range(0, 3));
                left = $urandom_range(5, 60);
            end
            left--;
            case (mode)
                STALL_NONE:     i_out_stall <= 1'b0;
                STALL_COIN:     i_out_stall <= 1'($urandom_range(0, 1));
                STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: i_out_stall <= (left % 4 == 0);
                default:        i_out_stall <= 1'b0;
            endcase
        end
    end

    task automatic send_region(input logic [OFF_BITS-1:0] offset,
                               input logic [ADDEND_BITS-1:0] addend,
                               input logic [TAG_BITS-1:0] tag, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        @(negedge i_clk);
        i_region_offset <= offset;
        i_padding_addend <= addend;
        i_source_tag <= tag;
        i_last_region <= last;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
        sent_items++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] index,
                             input logic [ADDR_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wr_data <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic configure_layout(input logic [OFF_BITS-1:0] size,
                                    input logic [ADDR_BITS-1:0] addr, input logic compressed);
        wait_drained();
        write_cfg(CFG_SECTION_SIZE, {32'($urandom), size});
        write_cfg(CFG_SECTION_ADDRESS, addr);
        write_cfg(CFG_COMPRESSED_MODE, {32'($urandom), 31'($urandom), compressed});
        cur_size = size;
        cur_gran_mask = compressed ? 32'd1 : 32'd3;
    endtask

    // mostly sorted, well-aligned regions with an occasional broken one
    task automatic send_section();
        int                     n;
        int                     k;
        logic [OFF_BITS-1:0]    cursor;
        logic [OFF_BITS-1:0]    offset;
        logic [ADDEND_BITS-1:0] addend;
        n = $urandom_range(1, 8);
        cursor = ($urandom_range(0, 3) == 0) ? (OFF_BITS'($urandom_range(0, cur_size))
                 & ~cur_gran_mask) : '0;
        for (int i = 0; i < n; i++) begin
            offset = cursor + (OFF_BITS'($urandom_range(0, 48)) & ~cur_gran_mask);
            if ($urandom_range(0, 3) == 0) begin
                addend = ADDEND_BITS'($urandom_range(0, 16)) * ADDEND_BITS'(cur_gran_mask + 1);
            end else begin
                k = $urandom_range((cur_gran_mask == 32'd1) ? 2 : 3, 8);
                addend = (ADDEND_BITS'(1) << k) - ADDEND_BITS'(cur_gran_mask + 1);
            end
            case ($urandom_range(0, 11))
                0: addend = {1'b1, 32'($urandom)};
                1: addend[0] = 1'b1;
                2: offset = cursor >> 1;
                3: offset = OFF_BITS'($urandom);
                default: ;
            endcase
            send_region(offset, addend, TAG_BITS'($urandom), i == n - 1);
            cursor = offset + addend[OFF_BITS-1:0];
        end
    endtask

    task automatic run_random_phase(input int count);
        int start;
        start = sent_items;
        while (sent_items - start < count) begin
            if ($urandom_range(0, 4) == 0)
                send_region(OFF_BITS'($urandom), {1'($urandom_range(0, 1)), 32'($urandom)},
                            TAG_BITS'($urandom), $urandom_range(0, 3) == 0);
            else
                send_section();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wr_data = '0;
        i_in_valid = 1'b0;
        i_region_offset = '0;
        i_padding_addend = '0;
        i_source_tag = '0;
        i_last_region = 1'b0;
        sent_items = 0;
        burst_left = 0;
        cur_size = '0;
        cur_gran_mask = 32'd3;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero padding, kept bytes, final size
        configure_layout(32'd4096, 64'h1000, 1'b1);
        send_region(32'd0, 33'd0, 16'hFFFF, 1'b0);
        send_region(32'd8, 33'd6, 16'h0000, 1'b0);
        send_region(32'd20, 33'd0, TAG_BITS'($urandom), 1'b0);
        send_region(32'd24, 33'd2, TAG_BITS'($urandom), 1'b0);
        send_region(32'd32, 33'd14, TAG_BITS'($urandom), 1'b1);
        // negative padding then aborted regions
        send_region(32'd0, 33'h1_0000_0000, TAG_BITS'($urandom), 1'b0);
        send_region(32'd4, 33'd2, TAG_BITS'($urandom), 1'b0);
        send_region(32'd8, 33'd2, TAG_BITS'($urandom), 1'b1);
        send_region(32'd0, 33'h1_FFFF_FFFF, TAG_BITS'($urandom), 1'b1);
        // out of range, region at the section end, granularity, overlap
        send_region(32'd4097, 33'd0, TAG_BITS'($urandom), 1'b0);
        send_region(32'd0, 33'd0, TAG_BITS'($urandom), 1'b1);
        send_region(32'd4090, 33'd8, TAG_BITS'($urandom), 1'b1);
        send_region(32'd4096, 33'd0, TAG_BITS'($urandom), 1'b1);
        send_region(32'd0, 33'd3, TAG_BITS'($urandom), 1'b1);
        send_region(32'd0, 33'd14, TAG_BITS'($urandom), 1'b0);
        send_region(32'd4, 33'd2, TAG_BITS'($urandom), 1'b1);

        // widest alignment and address overflow
        configure_layout(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
        send_region(32'd0, 33'h0_FFFF_FFFC, TAG_BITS'($urandom), 1'b0);
        send_region(32'hFFFF_FFFF, 33'd0, TAG_BITS'($urandom), 1'b0);
        send_region(32'hFFFF_FFFC, 33'd4, TAG_BITS'($urandom), 1'b1);
        send_region(32'h100, 33'd4, TAG_BITS'($urandom), 1'b1);
        send_region(32'd0, 33'h0_FFFF_FFFF, TAG_BITS'($urandom), 1'b1);

        // misaligned base makes alignment impossible
        configure_layout(32'd4096, 64'd2, 1'b0);
        send_region(32'd0, 33'd4, TAG_BITS'($urandom), 1'b1);

        configure_layout(32'd4096, 64'h0, 1'b1);
        run_random_phase(40);
        wait_drained();
        run_random_phase(40);

        configure_layout(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        write_cfg(CFG_INDEX_UNUSED, {32'($urandom), 32'($urandom)});
        run_random_phase(80);

        configure_layout(32'd0, 64'h0, 1'b1);
        run_random_phase(60);

        configure_layout(OFF_BITS'($urandom_range(256, 65536)),
                         {32'($urandom), 32'($urandom)} & ~64'h3, 1'($urandom_range(0, 1)));
        run_random_phase(80);

        configure_layout(OFF_BITS'($urandom), 64'hFFFF_FFFF_FFFF_0000, 1'b0);
        run_random_phase(80);

        configure_layout(32'd65536, {32'($urandom), 32'($urandom)} & ~64'h1, 1'b1);
        run_random_phase(80);

        configure_layout(OFF_BITS'($urandom_range(1024, 1 << 20)),
                         {32'($urandom), 32'($urandom)} & ~64'h7, 1'b0);
        run_random_phase(80);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
